>>> hw/rtl/tpio_pkg.sv
// ----------------------------------------------------------------------------
// tpio_pkg - trick-play index offset shared types
// Stage record handed along the divider chain, plus section codes.
// ----------------------------------------------------------------------------
package tpio_pkg;

  localparam int NUM_W = 33;  // dividend width (clamped timestamp span)
  localparam int DEN_W = 40;  // widest divisor register

  // section select carried down the chain
  localparam logic [1:0] SEC_PLAY = 2'd0;
  localparam logic [1:0] SEC_FWD  = 2'd1;
  localparam logic [1:0] SEC_RWD  = 2'd2;

  // direction field codes (two's complement)
  localparam logic [1:0] DIR_NORMAL = 2'b00;
  localparam logic [1:0] DIR_FWD    = 2'b01;
  localparam logic [1:0] DIR_UNUSED = 2'b10;  // treated as normal speed
  localparam logic [1:0] DIR_RWD    = 2'b11;

  // register indexes
  localparam logic [2:0] REG_PLAY_FIRST = 3'd0;
  localparam logic [2:0] REG_PLAY_LAST  = 3'd1;
  localparam logic [2:0] REG_PLAY_BIN   = 3'd2;
  localparam logic [2:0] REG_PLAY_CNT   = 3'd3;
  localparam logic [2:0] REG_FWD_DIV    = 3'd4;
  localparam logic [2:0] REG_FWD_CNT    = 3'd5;
  localparam logic [2:0] REG_RWD_DIV    = 3'd6;
  localparam logic [2:0] REG_RWD_CNT    = 3'd7;

  typedef struct packed {
    logic             vld;
    logic [1:0]       sec;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] nq;   // dividend bits shift out, quotient bits shift in
  } tpio_stage_t;

endpackage

>>> hw/rtl/trick_play_index_offset_unit.sv
// ----------------------------------------------------------------------------
// trick_play_index_offset_unit - timestamp to index-file byte offset
// Clamps a timestamp, divides by the section divisor in a bit-per-cell
// chain, caps, adds the section base and scales to a byte offset.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------
//  request  | start / busy (0)       | in_query_pts[33:0], in_direction[1:0]
//  result   | out_valid strobe       | out_byte_offset[31:0]
//  config   | psel/penable/pwrite    | paddr[5:3] index, pwdata[63:0]
//
//  One request per cycle; a result passes the entry stage, 33 divider
//  cells and the output stage. The cell count is set by the 33 quotient bits.
//  Synchronous active-low reset empties the chain; no clearing pass.
//  busy is never raised; results are strobed for one cycle, no stall.
// ----------------------------------------------------------------------------
module trick_play_index_offset_unit #(
  parameter int HEADER_BYTES = 104
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [33:0] in_query_pts,
  input  logic [1:0]  in_direction,
  output logic        out_valid,
  output logic [31:0] out_byte_offset,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import tpio_pkg::*;

  // configuration registers
  logic [32:0] play_first_r, play_last_r;
  logic [31:0] play_bin_r;
  logic [27:0] play_cnt_r, fwd_cnt_r, rwd_cnt_r;
  logic [39:0] fwd_div_r, rwd_div_r;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_first_r <= '0;
      play_last_r  <= '0;
      play_bin_r   <= 32'd1;
      play_cnt_r   <= 28'd1;
      fwd_div_r    <= 40'd1;
      fwd_cnt_r    <= 28'd1;
      rwd_div_r    <= 40'd1;
      rwd_cnt_r    <= 28'd1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PLAY_FIRST: play_first_r <= pwdata[32:0];
        REG_PLAY_LAST:  play_last_r  <= pwdata[32:0];
        REG_PLAY_BIN:   play_bin_r   <= pwdata[31:0];
        REG_PLAY_CNT:   play_cnt_r   <= pwdata[27:0];
        REG_FWD_DIV:    fwd_div_r    <= pwdata[39:0];
        REG_FWD_CNT:    fwd_cnt_r    <= pwdata[27:0];
        REG_RWD_DIV:    rwd_div_r    <= pwdata[39:0];
        REG_RWD_CNT:    rwd_cnt_r    <= pwdata[27:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PLAY_FIRST: prdata = {31'd0, play_first_r};
      REG_PLAY_LAST:  prdata = {31'd0, play_last_r};
      REG_PLAY_BIN:   prdata = {32'd0, play_bin_r};
      REG_PLAY_CNT:   prdata = {36'd0, play_cnt_r};
      REG_FWD_DIV:    prdata = {24'd0, fwd_div_r};
      REG_FWD_CNT:    prdata = {36'd0, fwd_cnt_r};
      REG_RWD_DIV:    prdata = {24'd0, rwd_div_r};
      REG_RWD_CNT:    prdata = {36'd0, rwd_cnt_r};
      default:        prdata = '0;
    endcase
  end

  // entry stage: clamp and form the dividend
  logic signed [34:0] pts_sx, lim_hi, lim_lo, pts_hi, pts_cl;
  logic [32:0]        span;
  tpio_stage_t        ent_nxt, ent_r;
  tpio_stage_t        chain [0:NUM_W];

  always_comb begin
    pts_sx = {in_query_pts[33], in_query_pts};
    lim_hi = {2'b00, play_last_r};
    lim_lo = {2'b00, play_first_r};
    pts_hi = (pts_sx > lim_hi) ? lim_hi : pts_sx;
    pts_cl = (pts_hi < lim_lo) ? lim_lo : pts_hi;
    span   = pts_cl[32:0] - play_first_r;   // never negative after clamp
    ent_nxt     = '0;
    ent_nxt.vld = start;
    case (in_direction)
      DIR_FWD: begin
        ent_nxt.sec = SEC_FWD;
        ent_nxt.den = fwd_div_r;
        ent_nxt.nq  = {1'b0, span[31:0]};
      end
      DIR_RWD: begin
        ent_nxt.sec = SEC_RWD;
        ent_nxt.den = rwd_div_r;
        // last - pts - first, 32-bit wrap
        ent_nxt.nq  = {1'b0, play_last_r[31:0] - pts_cl[31:0] - play_first_r[31:0]};
      end
      default: begin
        ent_nxt.sec = SEC_PLAY;
        ent_nxt.den = {8'd0, play_bin_r};
        ent_nxt.nq  = span;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
    end else begin
      ent_r.vld <= ent_nxt.vld;
    end
    ent_r.sec <= ent_nxt.sec;
    ent_r.den <= ent_nxt.den;
    ent_r.rem <= ent_nxt.rem;
    ent_r.nq  <= ent_nxt.nq;
  end

  assign chain[0] = ent_r;

  // divider chain: one quotient bit per cell; zero divisor yields all ones
  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    tpio_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .stg_i (chain[i]),
      .stg_o (chain[i+1])
    );
  end

  // output stage: cap at count-1, add section base, scale to bytes
  tpio_stage_t last_stg;
  logic [31:0] quo, lim, base, qcap, off_sum;
  logic        vld_r;
  logic [31:0] off_r, off_nxt;

  always_comb begin
    last_stg = chain[NUM_W];
    quo      = last_stg.nq[31:0];
    case (last_stg.sec)
      SEC_FWD: begin
        lim  = {4'd0, fwd_cnt_r} - 32'd1;
        base = {4'd0, play_cnt_r};
      end
      SEC_RWD: begin
        lim  = {4'd0, rwd_cnt_r} - 32'd1;
        base = {4'd0, play_cnt_r} + {4'd0, fwd_cnt_r};
      end
      default: begin
        lim  = {4'd0, play_cnt_r} - 32'd1;
        base = '0;
      end
    endcase
    qcap    = (quo < lim) ? quo : lim;
    off_sum = qcap + base;
    off_nxt = {off_sum[29:0], 2'b00} + 32'(HEADER_BYTES);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= last_stg.vld;
    end
    off_r <= off_nxt;
  end

  assign out_valid       = vld_r;
  assign out_byte_offset = off_r;

endmodule

>>> hw/rtl/tpio_cell.sv
// ----------------------------------------------------------------------------
// tpio_cell - one restoring-division step
// Resolves one quotient bit and passes the request to the next cell.
// ----------------------------------------------------------------------------
module tpio_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tpio_pkg::tpio_stage_t stg_i,
  output tpio_pkg::tpio_stage_t stg_o
);
  import tpio_pkg::*;

  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W:0]   diff;
  tpio_stage_t      stg_r, stg_nxt;

  always_comb begin
    trial = {stg_i.rem, stg_i.nq[NUM_W-1]};
    ge    = trial >= {1'b0, stg_i.den};
    diff  = trial - {1'b0, stg_i.den};
    stg_nxt     = stg_i;
    stg_nxt.rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    stg_nxt.nq  = {stg_i.nq[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.vld <= 1'b0;
    end else begin
      stg_r.vld <= stg_nxt.vld;
    end
    stg_r.sec <= stg_nxt.sec;
    stg_r.den <= stg_nxt.den;
    stg_r.rem <= stg_nxt.rem;
    stg_r.nq  <= stg_nxt.nq;
  end

  assign stg_o = stg_r;

endmodule

>>> tb/tb_trick_play_index_offset_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trick_play_index_offset_unit - offset unit self-checking bench
// Drives timestamp/direction requests through the command port, programs the
// section registers over APB between phases and checks each strobed byte
// offset against an in-bench predictor, oldest expectation first.
// ----------------------------------------------------------------------------
module tb_trick_play_index_offset_unit;
  import tpio_pkg::*;

  localparam int HDR       = 104;
  localparam int LAT       = 40;       // pipe depth plus margin
  localparam int MAX_CYC   = 400000;
  localparam int N_RANDOM  = 650;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [33:0] in_query_pts = '0;
  logic [1:0]  in_direction = '0;
  logic        out_valid;
  logic [31:0] out_byte_offset;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  trick_play_index_offset_unit #(.HEADER_BYTES(HDR)) u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor's copy of the register file
  logic [32:0] r_first, r_last;
  logic [31:0] r_bin;
  logic [27:0] r_pcnt, r_fcnt, r_rcnt;
  logic [39:0] r_fdiv, r_rdiv;

  logic [31:0] offset_q[$];
  int          n_err = 0;
  int          n_req = 0;
  int          n_res = 0;
  int          cyc = 0;
  int          sender_idle = 25;
  bit          dir_seen[4];

  // directed table: timestamp, direction, expected (typed only where obvious)
  typedef struct {
    logic [33:0] qpts;
    logic [1:0]  dir;
    logic [31:0] want;
    bit          typed;
  } row_t;

  row_t tbl[$];

  // work out the byte offset for one request
  function automatic logic [31:0] calc_offset(logic [33:0] qpts, logic [1:0] dir);
    logic signed [35:0] pts, first, last;
    logic [63:0]        num, den, quo;
    logic [31:0]        q, lim, base, off;
    logic [27:0]        cnt;
    pts   = {{2{qpts[33]}}, qpts};
    first = {3'b0, r_first};
    last  = {3'b0, r_last};
    if (pts > last) pts = last;
    if (pts < first) pts = first;  // inverted range lands on first
    if (dir == DIR_FWD) begin
      num  = {32'b0, 32'(pts - first)};
      den  = {24'b0, r_fdiv};
      cnt  = r_fcnt;
      base = 32'(r_pcnt);
    end else if (dir == DIR_RWD) begin
      // kept as the spec writes it: (last - pts) - first, 32-bit wrap
      num  = {32'b0, 32'(last - pts - first)};
      den  = {24'b0, r_rdiv};
      cnt  = r_rcnt;
      base = 32'(r_pcnt) + 32'(r_fcnt);
    end else begin
      num  = 64'(pts - first);
      den  = {32'b0, r_bin};
      cnt  = r_pcnt;
      base = '0;
    end
    quo = (den == 0) ? 64'hFFFF_FFFF : num / den;
    q   = quo[31:0];
    lim = 32'(cnt) - 32'd1;  // zero count: no cap
    if (lim < q) q = lim;
    off = q + base;
    return off * 32'd4 + 32'(HDR);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_res);
    n_err++;
  endtask

  // result side: one strobe, one result, no back-pressure
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst_n && out_valid) begin
      n_res++;
      if (offset_q.size() == 0) report("unexpected result", out_byte_offset, 'x);
      else begin
        logic [31:0] want;
        want = offset_q.pop_front();
        if (out_byte_offset !== want) report("byte_offset", out_byte_offset, want);
      end
    end
  end

  always @(posedge clk) begin
    if (cyc > MAX_CYC) begin
      $display("timeout after %0d cycles", cyc);
      $display("status: fail");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_PLAY_FIRST: r_first = val[32:0];
      REG_PLAY_LAST:  r_last  = val[32:0];
      REG_PLAY_BIN:   r_bin   = val[31:0];
      REG_PLAY_CNT:   r_pcnt  = val[27:0];
      REG_FWD_DIV:    r_fdiv  = val[39:0];
      REG_FWD_CNT:    r_fcnt  = val[27:0];
      REG_RWD_DIV:    r_rdiv  = val[39:0];
      REG_RWD_CNT:    r_rcnt  = val[27:0];
      default: ;
    endcase
  endtask

  task automatic cfg_all(logic [63:0] v[8]);
    for (int i = 0; i < 8; i++) cfg_write(3'(i), v[i]);
  endtask

  // hold the request port until the pipe has drained
  task automatic drain();
    while (offset_q.size() != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
  endtask

  // one request; start stays high across back-to-back requests
  task automatic send(logic [33:0] qpts, logic [1:0] dir, logic [31:0] want, bit typed);
    logic [31:0] pred;
    while ($urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1; in_query_pts <= qpts; in_direction <= dir;
    do @(posedge clk); while (busy);
    pred = calc_offset(qpts, dir);
    if (typed && pred !== want) report("typed row", pred, want);
    offset_q.insert(offset_q.size(), typed ? want : pred);
    dir_seen[dir] = 1'b1;
    n_req++;
  endtask

  // called right after an accepting edge: drop start before the next edge
  task automatic idle_sender();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_row(logic [33:0] qpts, logic [1:0] dir, logic [31:0] want, bit typed);
    row_t r;
    r.qpts  = qpts;
    r.dir   = dir;
    r.want  = want;
    r.typed = typed;
    tbl.insert(tbl.size(), r);
  endtask

  function automatic logic [33:0] rand_pts();
    case ($urandom_range(3))
      0: return 34'($urandom_range(200000));
      1: return {2'b11, 32'($urandom)};
      2: return {1'($urandom_range(1)), 1'b0, 32'($urandom)};
      default: return {2'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic logic [1:0] rand_dir();
    return 2'($urandom);  // includes the unused code
  endfunction

  task automatic random_cfg(int style);
    logic [63:0] v[8];
    logic [32:0] a, b;
    a = {1'($urandom), 32'($urandom)};
    b = {1'($urandom), 32'($urandom)};
    if (style == 0) begin
      // realistic title: small span, sensible bins
      a = 33'($urandom_range(100000));
      b = a + 33'($urandom_range(5000000));
      v = '{64'(a), 64'(b), 64'($urandom_range(1, 9000)), 64'($urandom_range(1, 2000)),
            64'($urandom_range(1, 90000)), 64'($urandom_range(1, 500)),
            64'($urandom_range(1, 90000)), 64'($urandom_range(1, 500))};
    end else begin
      v = '{64'(a), 64'(b), 64'($urandom_range(3)), {$urandom, $urandom},
            {$urandom, $urandom}, {$urandom, $urandom},
            64'($urandom_range(5)), {$urandom, $urandom}};
    end
    cfg_all(v);
  endtask

  initial begin
    logic [63:0] v[8];
    int phase_len;

    r_first = '0; r_last = '0; r_bin = 32'd1; r_pcnt = 28'd1;
    r_fdiv = 40'd1; r_fcnt = 28'd1; r_rdiv = 40'd1; r_rcnt = 28'd1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: first = last = 0, one entry per section
    add_row(34'd0, DIR_NORMAL, 32'd104, 1'b1);
    add_row(34'h1_FFFF_FFFF, DIR_FWD, 32'd108, 1'b1);
    add_row(34'h2_0000_0000, DIR_RWD, 32'd112, 1'b1);
    add_row(34'h3_FFFF_FFFF, DIR_UNUSED, 32'd104, 1'b1);
    foreach (tbl[i]) send(tbl[i].qpts, tbl[i].dir, tbl[i].want, tbl[i].typed);
    idle_sender();
    drain();

    // widest registers, zero divisors (all-ones quotient), zero counts (no cap)
    v = '{64'h1_FFFF_FFFF, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0};
    cfg_all(v);
    tbl.delete();
    // inverted range clamps to first; zero divisor and zero count give all ones
    add_row(34'd0, DIR_NORMAL, 32'd100, 1'b1);
    add_row(34'd5, DIR_FWD, 32'd100, 1'b1);
    add_row(34'h2_0000_0000, DIR_RWD, 32'd100, 1'b1);
    add_row(34'h1_FFFF_FFFF, DIR_UNUSED, 32'd100, 1'b1);
    foreach (tbl[i]) send(tbl[i].qpts, tbl[i].dir, tbl[i].want, tbl[i].typed);
    idle_sender();
    drain();

    // full-range maximum registers; wrapping sums are left to the predictor
    v = '{64'h0, 64'h1_FFFF_FFFF, 64'hFFFF_FFFF, 64'hFFF_FFFF,
          64'hFF_FFFF_FFFF, 64'hFFF_FFFF, 64'hFF_FFFF_FFFF, 64'hFFF_FFFF};
    cfg_all(v);
    tbl.delete();
    add_row(34'h1_FFFF_FFFF, DIR_NORMAL, 'x, 1'b0);
    add_row(34'h1_FFFF_FFFF, DIR_FWD, 'x, 1'b0);
    add_row(34'h0, DIR_RWD, 'x, 1'b0);
    add_row(34'h2_0000_0000, DIR_UNUSED, 'x, 1'b0);
    foreach (tbl[i]) send(tbl[i].qpts, tbl[i].dir, tbl[i].want, tbl[i].typed);
    idle_sender();
    drain();

    // small bins, rewind wrap of (last - pts) - first with first > 0
    v = '{64'd1000, 64'd50000, 64'd1, 64'd100000, 64'd3, 64'd20000, 64'd7, 64'd9000};
    cfg_all(v);
    tbl.delete();
    add_row(34'd999, DIR_NORMAL, 'x, 1'b0);
    add_row(34'd1000, DIR_FWD, 'x, 1'b0);
    add_row(34'd50000, DIR_RWD, 'x, 1'b0);
    add_row(34'd20000, DIR_RWD, 'x, 1'b0);
    add_row(34'd60000, DIR_NORMAL, 'x, 1'b0);
    add_row(34'd30000, DIR_UNUSED, 'x, 1'b0);
    foreach (tbl[i]) send(tbl[i].qpts, tbl[i].dir, tbl[i].want, tbl[i].typed);
    idle_sender();
    drain();

    // random phases: sender idles 25%, then 70%, then not at all
    phase_len = N_RANDOM / 9;
    for (int p = 0; p < 9; p++) begin
      sender_idle = (p < 3) ? 25 : (p < 6) ? 70 : 0;
      random_cfg((p % 3 == 2) ? 1 : 0);
      for (int k = 0; k < phase_len; k++) begin
        send(rand_pts(), rand_dir(), 'x, 0);
        if (k == phase_len / 2 && p == 4) begin
          // let the pipe empty completely mid-phase
          idle_sender();
          while (offset_q.size() != 0) @(posedge clk);
        end
      end
      idle_sender();
      drain();
    end

    $display("covered %0d requests, %0d results, all four direction codes: %0b",
             n_req, n_res, dir_seen[0] & dir_seen[1] & dir_seen[2] & dir_seen[3]);
    $display("register sets: reset, extremes, zero divisors and counts, random");
    if (n_err == 0 && offset_q.size() == 0) begin
      $display("status: pass");
    end else begin
      if (offset_q.size() != 0) $display("%0d results never arrived", offset_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
